[design/mi3_pkg.sv]
package mi3_pkg;

    localparam int EW = 32;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int DW = 97;
    localparam int NUMW = PW + EW;
    localparam int QBITS = EW + 1;
    localparam int DSW = DW + QBITS;
    localparam int MI3_QDEPTH = 4;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [CW-1:0] cof_t;
    typedef logic signed [DW-1:0] det_t;

    typedef struct packed {
        elem_t a11;
        elem_t a12;
        elem_t a13;
        elem_t a21;
        elem_t a22;
        elem_t a23;
        elem_t a31;
        elem_t a32;
        elem_t a33;
    } mi3_in_t;

    typedef struct packed {
        elem_t b11;
        elem_t b12;
        elem_t b13;
        elem_t b21;
        elem_t b22;
        elem_t b23;
        elem_t b31;
        elem_t b32;
        elem_t b33;
        logic  singular;
        logic  saturated;
    } mi3_out_t;

    typedef struct packed {
        cof_t [8:0] cof;
        det_t       det;
        logic       singular;
    } mi3_item_t;

    // Cofactor k is the product of elements 0 and 1 minus the product of elements 2 and 3.
    localparam int unsigned COF_IDX [0:8][0:3] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

endpackage

[design/mi3_front.sv]
module mi3_front import mi3_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mat_valid,
    output logic      mat_ready,
    input  mi3_in_t   mat,
    output logic      push_valid,
    input  logic      push_ready,
    output mi3_item_t push_item
);

    logic [5:0] vld_reg;
    logic       en;

    elem_t              a_in   [9];
    elem_t              a_reg  [9];
    logic signed [PW-1:0] prod_reg [18];
    elem_t              a2_reg [3];
    elem_t              a3_reg [3];
    cof_t               c3_reg [9];
    cof_t               c4_reg [9];
    cof_t               c5_reg [9];
    cof_t               c6_reg [9];
    logic [PW-1:0]      pl_reg [3];
    logic [PW-1:0]      ph_reg [3];
    logic               tneg_reg [3];
    logic [DW-1:0]      term_reg [3];
    det_t               det_reg;
    logic               sing_reg;

    assign en        = !vld_reg[5] || push_ready;
    assign mat_ready = en;

    assign a_in[0] = mat.a11;
    assign a_in[1] = mat.a12;
    assign a_in[2] = mat.a13;
    assign a_in[3] = mat.a21;
    assign a_in[4] = mat.a22;
    assign a_in[5] = mat.a23;
    assign a_in[6] = mat.a31;
    assign a_in[7] = mat.a32;
    assign a_in[8] = mat.a33;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], mat_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_in;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a_reg[i];
                a3_reg[i] <= a2_reg[i];
            end
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_cof
        logic signed [PW-1:0] p_next;
        logic signed [PW-1:0] q_next;
        assign p_next = PW'(a_reg[COF_IDX[k][0]]) * PW'(a_reg[COF_IDX[k][1]]);
        assign q_next = PW'(a_reg[COF_IDX[k][2]]) * PW'(a_reg[COF_IDX[k][3]]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[2*k]   <= p_next;
                prod_reg[2*k+1] <= q_next;
                c3_reg[k]       <= CW'(prod_reg[2*k]) - CW'(prod_reg[2*k+1]);
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_det
        logic [EW-1:0]   amag;
        cof_t            cneg;
        logic [PW-1:0]   cmag;
        logic [NUMW-1:0] mag;
        logic [DW-1:0]   term_next;
        always_comb
        begin
            amag      = a3_reg[i][EW-1] ? EW'(-a3_reg[i]) : EW'(a3_reg[i]);
            cneg      = -c3_reg[i];
            cmag      = c3_reg[i][CW-1] ? cneg[PW-1:0] : c3_reg[i][PW-1:0];
            mag       = {ph_reg[i], {EW{1'b0}}} + NUMW'(pl_reg[i]);
            term_next = tneg_reg[i] ? -DW'(mag) : DW'(mag);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pl_reg[i]   <= PW'(amag) * PW'(cmag[EW-1:0]);
                ph_reg[i]   <= PW'(amag) * PW'(cmag[PW-1:EW]);
                tneg_reg[i] <= a3_reg[i][EW-1] ^ c3_reg[i][CW-1];
                term_reg[i] <= term_next;
            end
        end
    end

    logic [DW-1:0] det_sum;
    assign det_sum = term_reg[0] + term_reg[1] + term_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= $signed(det_sum);
            sing_reg <= (det_sum == '0);
        end
    end

    assign push_valid         = vld_reg[5];
    assign push_item.det      = det_reg;
    assign push_item.singular = sing_reg;
    for (genvar k = 0; k < 9; k++)
    begin : g_out
        assign push_item.cof[k] = c6_reg[k];
    end

endmodule

[design/mi3_queue.sv]
module mi3_queue import mi3_pkg::*; #(
    parameter int DEPTH = MI3_QDEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  mi3_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output mi3_item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    mi3_item_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("Queue fill count exceeds its depth.");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue fill count did not grow on a push.");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("Queue fill count did not shrink on a pop.");

endmodule

[design/mi3_back.sv]
module mi3_back import mi3_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  mi3_item_t pop_item,
    output logic      inv_valid,
    input  logic      inv_ready,
    output mi3_out_t  inv
);

    localparam int NS = QBITS;

    logic [NS+1:0]     vld_reg;
    logic              en;
    logic [NUMW-1:0]   rem_reg  [0:NS][0:8];
    logic [QBITS-1:0]  q_reg    [0:NS][0:8];
    logic              neg_reg  [0:NS][0:8];
    logic              ovf_reg  [0:NS][0:8];
    logic [DW-1:0]     dab_reg  [0:NS];
    logic              sing_reg [0:NS];
    mi3_out_t          inv_reg;
    mi3_out_t          inv_next;
    logic [DW-1:0]     dab_in;
    det_t              det_neg;
    elem_t             res  [9];
    logic [8:0]        sat;

    assign en        = !vld_reg[NS+1] || inv_ready;
    assign pop_ready = en;
    assign inv_valid = vld_reg[NS+1];
    assign inv       = inv_reg;

    assign det_neg = -pop_item.det;
    assign dab_in  = pop_item.det[DW-1] ? det_neg : pop_item.det;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dab_reg[0]  <= dab_in;
            sing_reg[0] <= pop_item.singular;
        end
    end

    for (genvar l = 0; l < 9; l++)
    begin : g_load
        localparam int SRC = 3 * (l % 3) + l / 3;
        cof_t            cneg;
        logic [PW-1:0]   cmag;
        logic [NUMW-1:0] num;
        always_comb
        begin
            cneg = -pop_item.cof[SRC];
            cmag = pop_item.cof[SRC][CW-1] ? cneg[PW-1:0] : pop_item.cof[SRC][PW-1:0];
            num  = {cmag, {EW{1'b0}}};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0][l] <= num;
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= pop_item.cof[SRC][CW-1] ^ pop_item.det[DW-1];
                ovf_reg[0][l] <= DSW'(num) >= {dab_in, {QBITS{1'b0}}};
            end
        end
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        localparam int K = NS - s;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dab_reg[s]  <= dab_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
        end
        for (genvar l = 0; l < 9; l++)
        begin : g_lane
            logic [DSW-1:0] dsh;
            logic           take;
            assign dsh  = DSW'(dab_reg[s-1]) << K;
            assign take = DSW'(rem_reg[s-1][l]) >= dsh;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= take ? rem_reg[s-1][l] - dsh[NUMW-1:0] : rem_reg[s-1][l];
                    q_reg[s][l]   <= q_reg[s-1][l] | (take ? (QBITS'(1) << K) : '0);
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
        end
    end

    for (genvar l = 0; l < 9; l++)
    begin : g_fin
        logic [QBITS-1:0] lim;
        logic [QBITS-1:0] val;
        logic [QBITS-1:0] nval;
        always_comb
        begin
            lim    = neg_reg[NS][l] ? (QBITS'(1) << (EW - 1)) : ((QBITS'(1) << (EW - 1)) - 1'b1);
            sat[l] = !sing_reg[NS] && (ovf_reg[NS][l] || (q_reg[NS][l] > lim));
            val    = sat[l] ? lim : q_reg[NS][l];
            nval   = -val;
            if (sing_reg[NS])
            begin
                res[l] = '0;
            end
            else
            begin
                res[l] = neg_reg[NS][l] ? $signed(nval[EW-1:0]) : $signed(val[EW-1:0]);
            end
        end
    end

    always_comb
    begin
        inv_next.b11       = res[0];
        inv_next.b12       = res[1];
        inv_next.b13       = res[2];
        inv_next.b21       = res[3];
        inv_next.b22       = res[4];
        inv_next.b23       = res[5];
        inv_next.b31       = res[6];
        inv_next.b32       = res[7];
        inv_next.b33       = res[8];
        inv_next.singular  = sing_reg[NS];
        inv_next.saturated = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= inv_next;
        end
    end

endmodule

[design/matrix3_inverse.sv]
// Inverts one 3x3 Q16.16 matrix per item by the adjugate method and takes a new item every
// cycle unless the queue is full and holds the front pipeline. The front pipeline forms the
// exact cofactors and determinant and flags a singular matrix; a small queue then decouples
// it from the back pipeline, where nine division lanes of 33 one-bit stages plus a load and an
// output stage produce the quotients. Results are rounded toward zero and saturated; a zero
// determinant returns an all-zero matrix with the singular flag set.
module matrix3_inverse import mi3_pkg::*; #(
    parameter int QDEPTH = MI3_QDEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mat_valid,
    output logic     mat_ready,
    input  mi3_in_t  mat,
    output logic     inv_valid,
    input  logic     inv_ready,
    output mi3_out_t inv
);

    logic      push_valid;
    logic      push_ready;
    mi3_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    mi3_item_t pop_item;

    mi3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_ready  (mat_ready),
        .mat        (mat),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mi3_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mi3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .inv_valid (inv_valid),
        .inv_ready (inv_ready),
        .inv       (inv)
    );

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && inv.singular) |-> (inv.b11 == '0 && inv.b12 == '0 && inv.b13 == '0
            && inv.b21 == '0 && inv.b22 == '0 && inv.b23 == '0 && inv.b31 == '0
            && inv.b32 == '0 && inv.b33 == '0 && !inv.saturated))
        else $error("A singular item carries a nonzero element or a saturation flag.");

endmodule

[dv/tb.sv]
module tb;
    import mi3_pkg::*;

    localparam int IDLE_PCT = 28;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1000;

    logic     clk;
    logic     rst_n;
    logic     mat_valid;
    logic     mat_ready;
    mi3_in_t  mat;
    logic     inv_valid;
    logic     inv_ready;
    mi3_out_t inv;

    mi3_in_t  pending_mats[$];
    mi3_out_t expected_inverses[$];
    int       errors;
    int       stall_cycles;
    bit       quiet_phase;
    bit       all_sent;
    logic     mat_ready_seen;

    matrix3_inverse DUT (
        .clk(clk),
        .rst_n(rst_n),
        .mat_valid(mat_valid),
        .mat_ready(mat_ready),
        .mat(mat),
        .inv_valid(inv_valid),
        .inv_ready(inv_ready),
        .inv(inv)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] divide_q16(logic signed [64:0] cof,
                                                      logic signed [96:0] det,
                                                      inout bit sat);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [64:0]  cmag;
        bit           neg;
        logic [127:0] lim;
        begin
            cmag = cof[64] ? -cof : cof;
            num = {63'd0, cmag} << 32;
            den = det[96] ? {31'd0, -det} : {31'd0, det};
            quo = num / den;
            neg = cof[64] != det[96];
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (quo > lim)
            begin
                quo = lim;
                sat = 1'b1;
            end
            divide_q16 = neg ? -quo[31:0] : quo[31:0];
        end
    endfunction

    function automatic mi3_out_t invert(mi3_in_t m);
        logic signed [31:0]  e[9];
        logic signed [64:0]  c[9];
        logic signed [96:0]  det;
        logic signed [31:0]  r[9];
        bit                  sat;
        mi3_out_t            o;
        begin
            e = '{m.a11, m.a12, m.a13, m.a21, m.a22, m.a23, m.a31, m.a32, m.a33};
            c[0] = 65'(e[4]) * 65'(e[8]) - 65'(e[5]) * 65'(e[7]);
            c[1] = 65'(e[5]) * 65'(e[6]) - 65'(e[3]) * 65'(e[8]);
            c[2] = 65'(e[3]) * 65'(e[7]) - 65'(e[4]) * 65'(e[6]);
            c[3] = 65'(e[2]) * 65'(e[7]) - 65'(e[1]) * 65'(e[8]);
            c[4] = 65'(e[0]) * 65'(e[8]) - 65'(e[2]) * 65'(e[6]);
            c[5] = 65'(e[1]) * 65'(e[6]) - 65'(e[0]) * 65'(e[7]);
            c[6] = 65'(e[1]) * 65'(e[5]) - 65'(e[2]) * 65'(e[4]);
            c[7] = 65'(e[2]) * 65'(e[3]) - 65'(e[0]) * 65'(e[5]);
            c[8] = 65'(e[0]) * 65'(e[4]) - 65'(e[1]) * 65'(e[3]);
            det = 97'(e[0]) * 97'(c[0]) + 97'(e[1]) * 97'(c[1]) + 97'(e[2]) * 97'(c[2]);
            sat = 1'b0;
            o = '0;
            if (det == 0)
            begin
                o.singular = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        r[3 * i + j] = divide_q16(c[3 * j + i], det, sat);
                    end
                end
                o = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0, sat};
            end
            invert = o;
        end
    endfunction

    function automatic logic [31:0] random_elem(int mode);
        logic [31:0] v;
        begin
            case (mode)
                0: v = $urandom;
                1: v = $signed($urandom_range(0, 8)) - 4 <<< 16;
                2: v = $signed($urandom_range(0, 2047)) - 1024;
                default: v = $signed($urandom_range(0, 65535)) - 32768 <<< 8;
            endcase
            random_elem = v;
        end
    endfunction

    function automatic mi3_in_t random_mat();
        logic [31:0] e[9];
        int          mode;
        begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++)
            begin
                e[k] = ($urandom_range(0, 19) == 0) ? random_elem(0) : random_elem(mode);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                e[6] = e[3];
                e[7] = e[4];
                e[8] = e[5];
            end
            random_mat = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        end
    endfunction

    task automatic push_mat(logic [31:0] a11, logic [31:0] a12, logic [31:0] a13,
                            logic [31:0] a21, logic [31:0] a22, logic [31:0] a23,
                            logic [31:0] a31, logic [31:0] a32, logic [31:0] a33);
        pending_mats.push_back({a11, a12, a13, a21, a22, a23, a31, a32, a33});
    endtask

    initial
    begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        errors = 0;
        all_sent = 1'b0;
        rst_n = 1'b0;
        push_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        push_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
        push_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
        push_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
        push_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1);
        push_mat(MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV);
        push_mat(MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV);
        push_mat(MINV, MINV, MINV, MINV, MAXV, MINV, MINV, MAXV, MAXV);
        push_mat(2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE);
        push_mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                 9 * ONE);
        push_mat(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
        push_mat(ONE, ONE, 0, 0, ONE, 0, 0, 0, ONE);
        push_mat(-ONE, ONE, 0, 0, -ONE, 0, 0, 0, -ONE);
        push_mat(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hFFFF_FFFF,
                 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        push_mat(ONE << 8, 0, 0, 0, ONE << 8, 0, 0, 0, 1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pending_mats.push_back(random_mat());
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        quiet_phase <= ($time / 10) % 1200 >= 800;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
            mat <= '0;
            inv_ready <= 1'b0;
        end
        else
        begin
            inv_ready <= quiet_phase || ($urandom_range(1, 100) > IDLE_PCT);
            if (!mat_valid || mat_ready_seen)
            begin
                if (pending_mats.size() != 0 &&
                    (quiet_phase || $urandom_range(1, 100) > IDLE_PCT))
                begin
                    mat_valid <= 1'b1;
                    mat <= pending_mats.pop_front();
                end
                else
                begin
                    mat_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_ready_seen <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            mat_ready_seen <= mat_valid && mat_ready;
            if (mat_valid && mat_ready)
            begin
                expected_inverses.push_back(invert(mat));
            end
            if (inv_valid && inv_ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, inv);
                    errors <= errors + 1;
                end
                else
                begin
                    if (expected_inverses[0] !== inv)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 expected_inverses[0], inv);
                        errors <= errors + 1;
                    end
                    void'(expected_inverses.pop_front());
                end
            end
            if ((mat_valid && mat_ready) || (inv_valid && inv_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        wait (rst_n);
        wait (pending_mats.size() == 0 && !mat_valid && expected_inverses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_inverses.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
